FILE: src/oal_pkg.sv
// shared types, codes and defaults for the ordered array list
package oal_pkg;

	localparam int OAL_CAPACITY = 64;

	typedef enum logic [1:0] {
		ACT_INSERT,
		ACT_REMOVE,
		ACT_READ,
		ACT_CLEAR
	} oal_action_t;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_FULL      = 3'd1;
	localparam logic [2:0] ST_EMPTY     = 3'd2;
	localparam logic [2:0] ST_NOT_FOUND = 3'd3;
	localparam logic [2:0] ST_BEYOND    = 3'd4;

	typedef struct packed {
		oal_action_t        action;
		logic signed [31:0] value;
		logic [5:0]         index;
	} oal_req_t;

	typedef struct packed {
		logic [2:0]         status;
		logic signed [31:0] read_value;
		logic [6:0]         count;
		logic               is_empty;
	} oal_rsp_t;

	// commands broadcast to every cell of the row
	typedef struct packed {
		logic               insert;
		logic               remove;
		logic               bus_load;
		logic               bus_shift;
		logic signed [31:0] key;
	} oal_cell_ctl_t;

endpackage

FILE: src/oal_stream_if.sv
// valid/ready channel carrying one payload item
interface oal_stream_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

FILE: src/ordered_array_list.sv
// ordered_array_list: ordered list of signed 32-bit values in a row of CAPACITY cells.
// One item is taken at a time and gives one result; the next item is accepted as soon
// as the block is back in idle, even while the previous result still waits in the output
// register. Insert, clear, a read at or past the count and a remove on an empty list go
// straight to the result state. Any other remove, found or not, runs the log-step prefix
// scan that marks the first match and every cell above it; all marked cells then close
// the gap together. A read runs the read line, which moves the chosen entry one cell per
// cycle toward cell 0. A finished result that finds the output register still full waits
// until the receiver takes the older one. The count field shows the low 7 bits of the
// entry count.
module ordered_array_list import oal_pkg::*; #(
	parameter int CAPACITY = OAL_CAPACITY
) (
	input  logic         clk,
	input  logic         arst_n,
	oal_stream_if.sink   req,
	oal_stream_if.source rsp
);
	localparam int CW = $clog2(CAPACITY + 1);

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_SHIFT,
		S_READ,
		S_DONE
	} state_t;

	state_t             state_q;
	logic [CW-1:0]      count_q;
	logic [2:0]         status_q;
	logic signed [31:0] rdval_q;
	logic [5:0]         rd_left_q;
	logic               out_valid_q;
	oal_rsp_t           out_q;

	oal_cell_ctl_t      ctl;
	logic               acc;
	logic               full;
	logic               in_range;
	logic               found;
	logic               scan_load;
	logic               scan_done;
	logic [CAPACITY-1:0] match_w;
	logic [CAPACITY-1:0] sel_w;
	logic signed [31:0] data_w [CAPACITY];
	logic signed [31:0] bus_w [CAPACITY];

	assign req.ready = state_q == S_IDLE;
	assign acc       = req.valid && req.ready;
	assign full      = count_q == CW'(CAPACITY);
	assign in_range  = (CW + 6)'(req.data.index) < (CW + 6)'(count_q);
	assign found     = sel_w[CAPACITY-1];

	always_comb begin
		ctl.key       = req.data.value;
		ctl.insert    = acc && req.data.action == ACT_INSERT && !full;
		ctl.remove    = state_q == S_SHIFT && found;
		ctl.bus_load  = acc && req.data.action == ACT_READ && in_range;
		ctl.bus_shift = state_q == S_READ && rd_left_q != '0;
	end

	assign scan_load = acc && req.data.action == ACT_REMOVE && count_q != '0;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic signed [31:0] nxt_data;
		logic signed [31:0] nxt_bus;
		if (i < CAPACITY - 1) begin : g_mid
			assign nxt_data = data_w[i+1];
			assign nxt_bus  = bus_w[i+1];
		end else begin : g_end
			assign nxt_data = data_w[i];
			assign nxt_bus  = '0;
		end
		oal_cell #(
			.CW  (CW),
			.POS (i)
		) u_cell (
			.clk      (clk),
			.ctl      (ctl),
			.count    (count_q),
			.sel      (sel_w[i]),
			.nxt_data (nxt_data),
			.nxt_bus  (nxt_bus),
			.data     (data_w[i]),
			.bus      (bus_w[i]),
			.match    (match_w[i])
		);
	end

	oal_scan #(
		.N (CAPACITY)
	) u_scan (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (scan_load),
		.match  (match_w),
		.vec    (sel_w),
		.done   (scan_done)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			status_q    <= ST_OK;
			rdval_q     <= '0;
			rd_left_q   <= '0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			if (out_valid_q && rsp.ready && state_q != S_DONE) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (acc) begin
						rdval_q <= '0;
						case (req.data.action)
							ACT_INSERT: begin
								state_q <= S_DONE;
								if (full) begin
									status_q <= ST_FULL;
								end else begin
									status_q <= ST_OK;
									count_q  <= count_q + 1'b1;
								end
							end
							ACT_REMOVE: begin
								if (count_q == '0) begin
									status_q <= ST_EMPTY;
									state_q  <= S_DONE;
								end else begin
									status_q <= ST_OK;
									state_q  <= S_SCAN;
								end
							end
							ACT_READ: begin
								if (in_range) begin
									status_q  <= ST_OK;
									rd_left_q <= req.data.index;
									state_q   <= S_READ;
								end else begin
									status_q <= ST_BEYOND;
									state_q  <= S_DONE;
								end
							end
							ACT_CLEAR: begin
								status_q <= ST_OK;
								count_q  <= '0;
								state_q  <= S_DONE;
							end
							default: begin
								status_q <= ST_OK;
								count_q  <= '0;
								state_q  <= S_DONE;
							end
						endcase
					end
				end
				S_SCAN: begin
					if (scan_done) begin
						state_q <= S_SHIFT;
					end
				end
				S_SHIFT: begin
					if (found) begin
						count_q <= count_q - 1'b1;
					end else begin
						status_q <= ST_NOT_FOUND;
					end
					state_q <= S_DONE;
				end
				S_READ: begin
					if (rd_left_q == '0) begin
						rdval_q <= bus_w[0];
						state_q <= S_DONE;
					end else begin
						rd_left_q <= rd_left_q - 1'b1;
					end
				end
				S_DONE: begin
					// wait for the output register to free up
					if (!out_valid_q || rsp.ready) begin
						out_q.status     <= status_q;
						out_q.read_value <= rdval_q;
						out_q.count      <= 7'(count_q);
						out_q.is_empty   <= count_q == '0;
						out_valid_q      <= 1'b1;
						state_q          <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign rsp.valid = out_valid_q;
	assign rsp.data  = out_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("entry count above capacity");

	a_insert_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && req.data.action == ACT_INSERT && !full)
		|=> count_q == CW'($past(count_q) + 1'b1))
		else $error("insert did not grow the count");

	a_remove_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SHIFT && found) |=> count_q == CW'($past(count_q) - 1'b1))
		else $error("remove did not shrink the count");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && out_valid_q && !rsp.ready) |=> state_q == S_DONE)
		else $error("pending result overwritten");
endmodule

FILE: src/oal_cell.sv
// one list entry with its compare, close-gap shift and read line stage
module oal_cell import oal_pkg::*; #(
	parameter int CW  = 7,
	parameter int POS = 0
) (
	input  logic               clk,
	input  oal_cell_ctl_t      ctl,
	input  logic [CW-1:0]      count,
	input  logic               sel,
	input  logic signed [31:0] nxt_data,
	input  logic signed [31:0] nxt_bus,
	output logic signed [31:0] data,
	output logic signed [31:0] bus,
	output logic               match
);
	logic signed [31:0] data_q;
	logic signed [31:0] bus_q;

	always_ff @(posedge clk) begin
		if (ctl.insert && count == CW'(POS)) begin
			data_q <= ctl.key;
		end else if (ctl.remove && sel) begin
			data_q <= nxt_data;
		end
		if (ctl.bus_load) begin
			bus_q <= data_q;
		end else if (ctl.bus_shift) begin
			bus_q <= nxt_bus;
		end
	end

	assign match = (data_q == ctl.key) && (CW'(POS) < count);
	assign data  = data_q;
	assign bus   = bus_q;
endmodule

FILE: src/oal_scan.sv
// first-match mask by log-step prefix or over the cell match flags
module oal_scan import oal_pkg::*; #(
	parameter int N = OAL_CAPACITY
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         load,
	input  logic [N-1:0] match,
	output logic [N-1:0] vec,
	output logic         done
);
	localparam int STEPS = (N > 1) ? $clog2(N) : 1;
	localparam int SW    = (STEPS > 1) ? $clog2(STEPS) : 1;

	logic [N-1:0]  vec_q;
	logic [SW-1:0] step_q;
	logic          busy_q;
	logic          last;

	assign last = step_q == SW'(STEPS - 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
			vec_q  <= '0;
		end else if (load) begin
			vec_q  <= match;
			busy_q <= 1'b1;
			step_q <= '0;
		end else if (busy_q) begin
			// each bit collects the match flags of all lower positions
			vec_q <= vec_q | (vec_q << (32'd1 << step_q));
			if (last) begin
				busy_q <= 1'b0;
			end else begin
				step_q <= step_q + 1'b1;
			end
		end
	end

	assign vec  = vec_q;
	assign done = busy_q && last;
endmodule
